[sv/brb_pkg.sv]
// Shared types, constants and helpers for the byte ring buffer.
package brb_pkg;

    localparam int RING_BYTES  = 1024;
    localparam int LANES       = 8;
    localparam int MAX_LANES   = 8;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(RING_BYTES);
    localparam int BANK_W      = $clog2(LANES);
    localparam int ROW_W       = IDX_W - BANK_W;
    localparam int BANK_DEPTH  = RING_BYTES / LANES;
    localparam int CNT_W       = 4;
    localparam int TOT_W       = 10;

    // Opcode bit positions: bit 1 selects read, bit 0 selects all-or-nothing.
    localparam int OP_READ_BIT = 1;
    localparam int OP_AON_BIT  = 0;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [BANK_W-1:0] t_bank;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [CNT_W-1:0]  byte_count;
        logic [BYTE_W-1:0] in_byte_0;
        logic [BYTE_W-1:0] in_byte_1;
        logic [BYTE_W-1:0] in_byte_2;
        logic [BYTE_W-1:0] in_byte_3;
        logic [BYTE_W-1:0] in_byte_4;
        logic [BYTE_W-1:0] in_byte_5;
        logic [BYTE_W-1:0] in_byte_6;
        logic [BYTE_W-1:0] in_byte_7;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0]  moved_count;
        logic              success;
        logic [BYTE_W-1:0] out_byte_0;
        logic [BYTE_W-1:0] out_byte_1;
        logic [BYTE_W-1:0] out_byte_2;
        logic [BYTE_W-1:0] out_byte_3;
        logic [BYTE_W-1:0] out_byte_4;
        logic [BYTE_W-1:0] out_byte_5;
        logic [BYTE_W-1:0] out_byte_6;
        logic [BYTE_W-1:0] out_byte_7;
        logic [TOT_W-1:0]  bytes_stored;
        logic [TOT_W-1:0]  bytes_free;
    } t_rsp;

    // Per-bank storage command for one request.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] wdata;
    } t_bank_cmd;

    // Request outcome carried to the result stage.
    typedef struct packed {
        t_cnt              moved_count;
        logic              success;
        logic              is_read;
        t_bank             start_bank;
        logic [TOT_W-1:0]  bytes_stored;
        logic [TOT_W-1:0]  bytes_free;
    } t_plan;

    function automatic logic [BYTE_W-1:0] req_lane(t_req req, int k);
        logic [BYTE_W-1:0] v;
        unique case (k)
            0:       v = req.in_byte_0;
            1:       v = req.in_byte_1;
            2:       v = req.in_byte_2;
            3:       v = req.in_byte_3;
            4:       v = req.in_byte_4;
            5:       v = req.in_byte_5;
            6:       v = req.in_byte_6;
            7:       v = req.in_byte_7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/brb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/brb_ctrl.sv]
// Index keeping, admission decision and per-bank commands for the byte ring buffer.
module brb_ctrl
    import brb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_req      i_req,
    output t_bank_cmd o_cmd [LANES],
    output t_plan     o_plan
);

    t_idx r_rd_idx, n_rd_idx;
    t_idx r_wr_idx, n_wr_idx;

    logic is_read;
    logic aon;
    t_cnt want;
    t_cnt moved;
    t_idx avail;
    t_idx start;

    always_comb begin
        is_read = i_req.opcode[OP_READ_BIT];
        aon     = i_req.opcode[OP_AON_BIT];

        // Clamp oversized requests to the lane count.
        if (i_req.byte_count > CNT_W'(LANES)) begin
            want = CNT_W'(LANES);
        end else begin
            want = i_req.byte_count;
        end

        avail = is_read ? (r_wr_idx - r_rd_idx - t_idx'(1)) : (r_rd_idx - r_wr_idx);

        priority if (avail >= t_idx'(want)) begin
            moved = want;
        end else if (aon) begin
            moved = '0;
        end else begin
            moved = avail[CNT_W-1:0];
        end

        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        if (is_read) begin
            n_rd_idx = r_rd_idx + t_idx'(moved);
        end else begin
            n_wr_idx = r_wr_idx + t_idx'(moved);
        end

        start = is_read ? (r_rd_idx + t_idx'(1)) : r_wr_idx;

        o_plan.moved_count  = moved;
        o_plan.success      = (moved == want);
        o_plan.is_read      = is_read;
        o_plan.start_bank   = start[BANK_W-1:0];
        o_plan.bytes_stored = TOT_W'(n_wr_idx - n_rd_idx - t_idx'(1));
        o_plan.bytes_free   = TOT_W'(n_rd_idx - n_wr_idx);
    end

    // Each of the consecutive slots of one request lands in a different bank.
    always_comb begin
        t_bank k;
        t_idx  addr;
        for (int b = 0; b < LANES; b++) begin
            k             = t_bank'(b) - start[BANK_W-1:0];
            addr          = start + t_idx'(k);
            o_cmd[b].row  = addr[IDX_W-1:BANK_W];
            o_cmd[b].we   = i_accept && !is_read && (t_cnt'(k) < moved);
            o_cmd[b].re   = i_accept && is_read;
            o_cmd[b].wdata = req_lane(i_req, int'(k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= t_idx'(1);
        end else if (i_accept) begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
        end
    end

endmodule

[sv/byte_ring_buffer.sv]
// Top level of the byte ring buffer: banked byte store, control and result register.
// An accepted request is registered in stage B, then in the result register once that is free.
// Throughput: one request per cycle unless the output stalls; eight banks, one per byte lane, take all request bytes.
// Reset: read index to zero, write index to one (store empty); stored bytes keep no reset.
// Reset empties both pipeline stages; no clearing pass is run.
module byte_ring_buffer
    import brb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    t_bank_cmd w_cmd [LANES];
    t_plan     w_plan;
    logic [BYTE_W-1:0] w_rdata [LANES];

    // Stage B: request decided, bank read data arriving.
    logic  r_b_valid;
    t_plan r_b_plan;
    // Stage C: result register facing the output channel.
    logic  r_c_valid;
    t_rsp  r_c_rsp;
    t_rsp  n_c_rsp;

    logic c_free;
    logic accept;

    // The result register can take a new request when it is empty or being drained.
    assign c_free     = !r_c_valid || !i_out_stall;
    // Hold the input only when stage B holds a request that cannot advance.
    assign o_in_stall = r_b_valid && !c_free;
    assign accept     = i_in_valid && !o_in_stall;

    brb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .o_cmd    (w_cmd),
        .o_plan   (w_plan)
    );

    // One bank per lane; slot address a lives in bank a mod LANES, row a / LANES.
    // Reads only fire on an accepted read, so bank outputs hold while stage B waits.
    for (genvar b = 0; b < LANES; b++) begin : g_bank
        brb_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_cmd[b].we),
            .i_waddr (w_cmd[b].row),
            .i_wdata (w_cmd[b].wdata),
            .i_re    (w_cmd[b].re),
            .i_raddr (w_cmd[b].row),
            .o_rdata (w_rdata[b])
        );
    end

    // Rotate bank data back into lane order and zero every lane that was not read.
    always_comb begin
        logic [BYTE_W-1:0] lane [MAX_LANES];
        t_bank             bank;
        for (int k = 0; k < MAX_LANES; k++) begin
            bank    = r_b_plan.start_bank + t_bank'(k);
            lane[k] = '0;
            if ((k < LANES) && r_b_plan.is_read && (t_cnt'(k) < r_b_plan.moved_count)) begin
                lane[k] = w_rdata[bank];
            end
        end
        n_c_rsp.moved_count  = r_b_plan.moved_count;
        n_c_rsp.success      = r_b_plan.success;
        n_c_rsp.out_byte_0   = lane[0];
        n_c_rsp.out_byte_1   = lane[1];
        n_c_rsp.out_byte_2   = lane[2];
        n_c_rsp.out_byte_3   = lane[3];
        n_c_rsp.out_byte_4   = lane[4];
        n_c_rsp.out_byte_5   = lane[5];
        n_c_rsp.out_byte_6   = lane[6];
        n_c_rsp.out_byte_7   = lane[7];
        n_c_rsp.bytes_stored = r_b_plan.bytes_stored;
        n_c_rsp.bytes_free   = r_b_plan.bytes_free;
    end

    // Advance stage B on accept; drop it once it moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (c_free) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_plan <= w_plan;
        end
    end

    // Load the result register whenever it is free; hold it while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_free && r_b_valid) begin
            r_c_rsp <= n_c_rsp;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_out_rsp   = r_c_rsp;

endmodule
